>>> sv/sit_pkg.sv
// ----------------------------------------------------------------------------
// Sorted image table package
// Shared sizes, record layout, command/status codes and configuration
// register indexes for the sorted image table and its record memory.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths
  localparam int unsigned BASE_W   = 64;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned UADDR_W  = 64;
  localparam int unsigned ULEN_W   = 32;
  localparam int unsigned CAP_W    = 9;
  localparam int unsigned SLOT_W   = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned EXT_W    = CNT_W + CAP_W;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'b1;

  // One image record as stored in memory
  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [SIZE_W-1:0]  size;
    logic [UADDR_W-1:0] uaddr;
    logic [ULEN_W-1:0]  ulen;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

>>> sv/sorted_image_table_insert_remove.sv
// ----------------------------------------------------------------------------
// Sorted image table, insert and remove
// Keeps image records sorted by base in one record memory; insert searches
// and shifts up, remove searches for an exact base and shifts down.
// ----------------------------------------------------------------------------
// An insert into a full table reports in the cycle after the request.
// Otherwise the search and the shift pass the n held entries, one per cycle
// through the single read and write port; an insert reads its slot twice.
// Busy is high until the strobe; one request at a time. Reset clears the
// count, overflow flag and sequencer registers, not the request payload or
// the record memory.
`default_nettype none

module sorted_image_table_insert_remove
  import sit_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // request
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   cmd_i,
  input  wire logic [BASE_W-1:0]      image_base_i,
  input  wire logic [SIZE_W-1:0]      image_size_i,
  input  wire logic [UADDR_W-1:0]     unwind_table_addr_i,
  input  wire logic [ULEN_W-1:0]      unwind_table_len_i,
  // result
  output logic                        done_o,
  output logic      [STATUS_W-1:0]    status_o,
  output logic      [SLOT_W-1:0]      slot_o,
  output logic      [SLOT_W-1:0]      entry_count_o,
  output logic                        overflow_o,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_FINISH
  } state_e;

  state_e              state_q;
  logic                cmd_q;
  entry_t              req_q;
  logic [CNT_W-1:0]    count_q;
  logic                overflow_q;
  logic [BASE_W-1:0]   primary_q;
  logic [CAP_W-1:0]    capacity_q;
  logic [CNT_W-1:0]    ra_q;
  logic                cmp_vld_q;
  logic [CNT_W-1:0]    cmp_idx_q;
  logic [CNT_W-1:0]    pos_q;
  logic                sh_rd_q;
  logic                wv_q;
  logic [CNT_W-1:0]    wa_q;
  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [CNT_W-1:0]    slot_q;

  entry_t              rdata;
  logic                full;
  logic                ins_hit;
  logic                rem_hit;
  logic                hit;
  logic                scan_rd;
  logic                sh_rd;
  logic                mem_re;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic                ins_op;
  logic                sh_last;

  assign busy   = (state_q != S_IDLE);
  assign ins_op = (cmd_q == CMD_INSERT);

  // Full when count reaches the capacity or the physical depth
  assign full = (EXT_W'(count_q) >= EXT_W'(capacity_q)) ||
                (count_q == CNT_W'(TABLE_DEPTH));

  // Search compare on the entry read last cycle; slot zero holding the
  // primary image is skipped by insert
  assign ins_hit = (req_q.base < rdata.base) &&
                   !((cmp_idx_q == '0) && (rdata.base == primary_q));
  assign rem_hit = (rdata.base == req_q.base);
  assign hit     = (state_q == S_SCAN) && cmp_vld_q && (ins_op ? ins_hit : rem_hit);

  // Memory read and write control
  assign scan_rd   = (state_q == S_SCAN) && !hit && (ra_q < count_q);
  assign sh_rd     = (state_q == S_SHIFT) && sh_rd_q;
  assign mem_re    = scan_rd || sh_rd;
  assign mem_we    = ((state_q == S_SHIFT) && wv_q) || (state_q == S_PUT);
  assign mem_waddr = (state_q == S_PUT) ? pos_q[IDX_W-1:0] : wa_q[IDX_W-1:0];
  assign mem_wdata = (state_q == S_PUT) ? req_q : rdata;
  assign sh_last   = ins_op ? (ra_q == pos_q) : (ra_q == count_q - CNT_W'(1));

  sit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (ra_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q       <= cmd_i;
      req_q.base  <= image_base_i;
      req_q.size  <= image_size_i;
      req_q.uaddr <= unwind_table_addr_i;
      req_q.ulen  <= unwind_table_len_i;
    end
  end

  // Sequencer, table state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      overflow_q <= 1'b0;
      primary_q  <= '0;
      capacity_q <= CAP_W'(TABLE_DEPTH);
      ra_q       <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      pos_q      <= '0;
      sh_rd_q    <= 1'b0;
      wv_q       <= 1'b0;
      wa_q       <= '0;
      done_q     <= 1'b0;
      status_q   <= ST_INSERTED;
      slot_q     <= '0;
    end else begin
      done_q <= 1'b0;

      // Configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRIMARY_BASE: primary_q  <= cfg_wdata_i;
          CFG_CAPACITY:     capacity_q <= cfg_wdata_i[CAP_W-1:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (start) begin
            if ((cmd_i == CMD_INSERT) && full) begin
              overflow_q <= 1'b1;
              status_q   <= ST_FULL;
              slot_q     <= '0;
              done_q     <= 1'b1;
            end else begin
              ra_q      <= '0;
              cmp_vld_q <= 1'b0;
              state_q   <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // Advance the search one entry per cycle
          cmp_vld_q <= scan_rd;
          cmp_idx_q <= ra_q;
          if (scan_rd) begin
            ra_q <= ra_q + CNT_W'(1);
          end
          if (hit) begin
            pos_q     <= cmp_idx_q;
            cmp_vld_q <= 1'b0;
            wv_q      <= 1'b0;
            if (ins_op) begin
              ra_q    <= count_q - CNT_W'(1);
              sh_rd_q <= 1'b1;
              state_q <= S_SHIFT;
            end else if (cmp_idx_q + CNT_W'(1) < count_q) begin
              ra_q    <= cmp_idx_q + CNT_W'(1);
              sh_rd_q <= 1'b1;
              state_q <= S_SHIFT;
            end else begin
              state_q <= S_FINISH;
            end
          end else if (ra_q == count_q) begin
            cmp_vld_q <= 1'b0;
            if (ins_op) begin
              pos_q   <= count_q;
              state_q <= S_PUT;
            end else begin
              status_q <= ST_NOT_FOUND;
              slot_q   <= '0;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end

        S_SHIFT: begin
          // Read one entry, write it to its neighbor once the read data is registered
          if (sh_rd_q) begin
            wv_q <= 1'b1;
            wa_q <= ins_op ? ra_q + CNT_W'(1) : ra_q - CNT_W'(1);
            if (sh_last) begin
              sh_rd_q <= 1'b0;
            end else begin
              ra_q <= ins_op ? ra_q - CNT_W'(1) : ra_q + CNT_W'(1);
            end
          end else begin
            wv_q    <= 1'b0;
            state_q <= ins_op ? S_PUT : S_FINISH;
          end
        end

        S_PUT: begin
          count_q  <= count_q + CNT_W'(1);
          status_q <= ST_INSERTED;
          slot_q   <= pos_q;
          done_q   <= 1'b1;
          state_q  <= S_IDLE;
        end

        S_FINISH: begin
          count_q  <= count_q - CNT_W'(1);
          status_q <= ST_REMOVED;
          slot_q   <= pos_q;
          done_q   <= 1'b1;
          state_q  <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_o        = SLOT_W'(slot_q);
  assign entry_count_o = SLOT_W'(count_q);
  assign overflow_o    = overflow_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |=> overflow_q)
    else $error("overflow flag cleared");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("memory write while idle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result strobe while busy");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SHIFT) && wv_q) |-> (wa_q < CNT_W'(TABLE_DEPTH)))
    else $error("shift write beyond table depth");
`endif

endmodule

`default_nettype wire

>>> sv/sit_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
